// File: sv/smax_pkg.sv
// Package for the softmax block: item and result types, status and register codes,
// and the fixed-point constants of the exponential. Used by softmax_along_axis and smax_div.
`default_nettype none

package smax_pkg;

	localparam int MAX_ELEMENTS_DEF  = 1024;
	localparam int MAX_SUM_SLOTS_DEF = 256;
	localparam int MAX_AXIS_DEF      = 256;

	localparam int DIV_W = 64;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EARLY = 2'd2;
	localparam logic [1:0] ST_SAT   = 2'd3;

	localparam logic [1:0] REG_OUTER = 2'd0;
	localparam logic [1:0] REG_AXIS  = 2'd1;
	localparam logic [1:0] REG_INNER = 2'd2;

	localparam logic       CMD_LOAD = 1'b0;
	localparam logic       CMD_READ = 1'b1;

	localparam logic [57:0] LN2_Q58 = 58'h2C5C85FDF473DE7;
	localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
	localparam logic [47:0] EXP_MAX = 48'hFFFFFFFFFFFF;
	localparam logic [55:0] SUM_MAX = 56'hFFFFFFFFFFFFFF;
	localparam logic [4:0]  LAST_TERM = 5'd24;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] logit;
	} item_t;

	typedef struct packed {
		logic [16:0] probability;
		logic        last;
		logic [1:0]  status;
	} result_t;

endpackage

`default_nettype wire

// File: sv/softmax_along_axis.sv
// Top level of the softmax block: sequencer, counters, exponential series and output register.
// Depends on smax_pkg, smax_ram and smax_div.
`default_nettype none

// Softmax along one axis of an outer x axis x inner tensor in fixed point. Load items
// deliver Q4.11 logits in lexical order; each is turned into exp() in Q24.24 by range
// reduction and a 24-term series, stored, and added into its (outer, inner) sum slot.
// Read items then return exp / slot sum in Q1.16, rounded. The block takes one item at a
// time and holds stall high while it works. A load does a five-step range reduction by
// compare and subtract, then 24 series terms, each a 32 x 32 multiply of four partial
// products and a division on the one shared bit-serial divider. A read makes one pass
// of that divider unless its slot sum is zero. Configuration writes abort any tensor
// in progress.
module softmax_along_axis #(
	parameter int MAX_ELEMENTS  = smax_pkg::MAX_ELEMENTS_DEF,
	parameter int MAX_SUM_SLOTS = smax_pkg::MAX_SUM_SLOTS_DEF,
	parameter int MAX_AXIS      = smax_pkg::MAX_AXIS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [10:0]       wr_data,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire smax_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output smax_pkg::result_t      result
);

	localparam int ADDR_W = $clog2(MAX_ELEMENTS);
	localparam int POS_W  = $clog2(MAX_ELEMENTS + 1);
	localparam int SLOT_W = (MAX_SUM_SLOTS > 1) ? $clog2(MAX_SUM_SLOTS) : 1;
	localparam int BASE_W = $clog2(MAX_SUM_SLOTS + 1);
	localparam int AXIS_W = $clog2(MAX_AXIS);
	localparam int CW     = 16;
	localparam int W      = smax_pkg::DIV_W;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SHAPE1   = 4'd1;
	localparam logic [3:0] S_SHAPE2   = 4'd2;
	localparam logic [3:0] S_CHECK    = 4'd3;
	localparam logic [3:0] S_RED_GO   = 4'd4;
	localparam logic [3:0] S_RED_WAIT = 4'd5;
	localparam logic [3:0] S_MUL      = 4'd6;
	localparam logic [3:0] S_TERM_GO  = 4'd7;
	localparam logic [3:0] S_TERM_WT  = 4'd8;
	localparam logic [3:0] S_FINAL    = 4'd9;
	localparam logic [3:0] S_WRITE    = 4'd10;
	localparam logic [3:0] S_RD_GO    = 4'd11;
	localparam logic [3:0] S_RD_WAIT  = 4'd12;
	localparam logic [3:0] S_OUT      = 4'd13;

	logic [3:0]         state_q;
	logic [10:0]        outer_q;
	logic [8:0]         axis_q;
	logic [10:0]        inner_q;
	logic [21:0]        slots_q;
	logic [30:0]        total_q;
	logic [POS_W-1:0]   load_pos_q;
	logic [POS_W-1:0]   read_pos_q;
	logic [AXIS_W-1:0]  axis_pos_q;
	logic [SLOT_W-1:0]  inner_pos_q;
	logic [BASE_W-1:0]  slot_base_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               cmd_q;
	logic signed [15:0] logit_q;
	logic [2:0]         mc_q;
	logic [4:0]         k_q;
	logic [5:0]         sh_q;
	logic [63:0]        x_q;
	logic [63:0]        term_q;
	logic [63:0]        sum_q;
	logic [127:0]       acc_q;
	logic [63:0]        pp_s1;
	logic [1:0]         sh_s1;
	logic [47:0]        e_q;
	logic               sat_q;
	logic [62:0]        red_rem_q;
	logic [4:0]         red_quo_q;
	logic [2:0]         red_bit_q;
	smax_pkg::result_t  pend_q;
	smax_pkg::result_t  result_q;
	logic               result_valid_q;

	logic               cfg_hit;
	logic               inner_wrap;
	logic               axis_wrap;
	logic [SLOT_W-1:0]  nxt_inner;
	logic [AXIS_W-1:0]  nxt_axis;
	logic [BASE_W-1:0]  nxt_base;
	logic [BASE_W:0]    slot_sum;
	logic [SLOT_W-1:0]  slot_c;
	logic               bad_shape;
	logic               loaded;
	logic               load_end;
	logic               read_end;
	logic [15:0]        mag;
	logic [62:0]        red_den;
	logic               red_fit;
	logic [62:0]        red_rem_nxt;
	logic [4:0]         red_quo_nxt;
	logic               red_done;
	logic [4:0]         q0;
	logic [57:0]        r0;
	logic [64:0]        rnd;
	logic [64:0]        e_full;
	logic [56:0]        sum_new;
	logic [55:0]        old_sum;
	logic               round_up;
	logic [31:0]        a_half;
	logic [31:0]        b_half;

	logic               div_start;
	logic [W-1:0]       div_dividend;
	logic [W-1:0]       div_divisor;
	logic               div_busy;
	logic               div_done;
	logic [W-1:0]       div_quo;
	logic [W-1:0]       div_rem;

	logic               exp_we;
	logic               exp_re;
	logic [47:0]        exp_rd;
	logic               sum_we;
	logic               sum_re;
	logic [55:0]        sum_rd;

	assign cfg_hit = wr_en && (wr_index == smax_pkg::REG_OUTER ||
	                           wr_index == smax_pkg::REG_AXIS ||
	                           wr_index == smax_pkg::REG_INNER);

	assign inner_wrap = CW'(inner_pos_q) + CW'(1) >= CW'(inner_q);
	assign axis_wrap  = CW'(axis_pos_q) + CW'(1) >= CW'(axis_q);
	assign nxt_inner  = inner_wrap ? '0 : SLOT_W'(CW'(inner_pos_q) + CW'(1));
	assign nxt_axis   = !inner_wrap ? axis_pos_q :
	                    (axis_wrap ? '0 : AXIS_W'(CW'(axis_pos_q) + CW'(1)));
	assign nxt_base   = (inner_wrap && axis_wrap) ?
	                    BASE_W'(CW'(slot_base_q) + CW'(inner_q)) : slot_base_q;

	assign slot_sum = (BASE_W+1)'(slot_base_q) + (BASE_W+1)'(inner_pos_q);
	assign slot_c   = (32'(slot_sum) >= 32'(MAX_SUM_SLOTS)) ?
	                  SLOT_W'(MAX_SUM_SLOTS - 1) : slot_sum[SLOT_W-1:0];

	assign bad_shape = (outer_q == '0) || (axis_q == '0) || (inner_q == '0) ||
	                   (32'(axis_q) > 32'(MAX_AXIS)) ||
	                   (32'(slots_q) > 32'(MAX_SUM_SLOTS)) ||
	                   (32'(total_q) > 32'(MAX_ELEMENTS));
	assign loaded    = 32'(load_pos_q) >= 32'(total_q);
	assign load_end  = 32'(load_pos_q) + 32'd1 >= 32'(total_q);
	assign read_end  = 32'(read_pos_q) + 32'd1 >= 32'(total_q);

	assign mag = logit_q[15] ? (~logit_q + 16'd1) : logit_q;

	assign red_den     = {5'd0, smax_pkg::LN2_Q58} << red_bit_q;
	assign red_fit     = red_rem_q >= red_den;
	assign red_rem_nxt = red_fit ? (red_rem_q - red_den) : red_rem_q;
	assign red_quo_nxt = red_quo_q | ({4'd0, red_fit} << red_bit_q);
	assign red_done    = (state_q == S_RED_WAIT) && (red_bit_q == 3'd0);

	assign q0  = red_quo_nxt;
	assign r0  = red_rem_nxt[57:0];

	assign rnd    = 65'(sum_q) + (65'(1) << (sh_q - 6'd1));
	assign e_full = rnd >> sh_q;

	assign old_sum  = (axis_pos_q == '0) ? '0 : sum_rd;
	assign sum_new  = 57'(old_sum) + 57'(e_q);
	assign round_up = {div_rem, 1'b0} >= {9'd0, sum_rd};

	assign a_half = mc_q[0] ? term_q[63:32] : term_q[31:0];
	assign b_half = mc_q[1] ? x_q[63:32] : x_q[31:0];

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			S_TERM_GO: begin
				div_start    = 1'b1;
				div_dividend = acc_q[125:62];
				div_divisor  = {59'd0, k_q};
			end
			S_RD_GO: begin
				div_start    = sum_rd != '0;
				div_dividend = {exp_rd, 16'd0};
				div_divisor  = {8'd0, sum_rd};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign exp_we = state_q == S_WRITE;
	assign sum_we = state_q == S_WRITE;
	assign exp_re = state_q == S_CHECK;
	assign sum_re = state_q == S_CHECK;

	smax_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	smax_ram #(
		.WIDTH (48),
		.DEPTH (MAX_ELEMENTS)
	) u_exp_ram (
		.clk     (clk),
		.we      (exp_we),
		.wr_addr (load_pos_q[ADDR_W-1:0]),
		.wr_data (e_q),
		.re      (exp_re),
		.rd_addr (read_pos_q[ADDR_W-1:0]),
		.rd_data (exp_rd)
	);

	smax_ram #(
		.WIDTH (56),
		.DEPTH (MAX_SUM_SLOTS)
	) u_sum_ram (
		.clk     (clk),
		.we      (sum_we),
		.wr_addr (slot_q),
		.wr_data (sum_new[56] ? smax_pkg::SUM_MAX : sum_new[55:0]),
		.re      (sum_re),
		.rd_addr (slot_c),
		.rd_data (sum_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			outer_q        <= 11'd1;
			axis_q         <= 9'd1;
			inner_q        <= 11'd1;
			load_pos_q     <= '0;
			read_pos_q     <= '0;
			axis_pos_q     <= '0;
			inner_pos_q    <= '0;
			slot_base_q    <= '0;
			mc_q           <= '0;
			k_q            <= '0;
		end else begin
			if (cfg_hit) begin
				if (wr_index == smax_pkg::REG_OUTER) begin
					outer_q <= wr_data;
				end
				if (wr_index == smax_pkg::REG_AXIS) begin
					axis_q <= wr_data[8:0];
				end
				if (wr_index == smax_pkg::REG_INNER) begin
					inner_q <= wr_data;
				end
				load_pos_q  <= '0;
				read_pos_q  <= '0;
				axis_pos_q  <= '0;
				inner_pos_q <= '0;
				slot_base_q <= '0;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (item_valid) begin
							state_q <= S_SHAPE1;
						end
					end
					S_SHAPE1: state_q <= S_SHAPE2;
					S_SHAPE2: state_q <= S_CHECK;
					S_CHECK: begin
						priority if (bad_shape) begin
							state_q <= S_OUT;
						end else if (cmd_q == smax_pkg::CMD_LOAD && loaded) begin
							state_q <= S_OUT;
						end else if (cmd_q == smax_pkg::CMD_READ && !loaded) begin
							state_q <= S_OUT;
						end else if (cmd_q == smax_pkg::CMD_LOAD) begin
							state_q <= S_RED_GO;
						end else begin
							state_q <= S_RD_GO;
						end
					end
					S_RED_GO: state_q <= S_RED_WAIT;
					S_RED_WAIT: begin
						if (red_done) begin
							k_q     <= 5'd1;
							mc_q    <= '0;
							state_q <= S_MUL;
						end
					end
					S_MUL: begin
						mc_q <= mc_q + 3'd1;
						if (mc_q == 3'd4) begin
							state_q <= S_TERM_GO;
						end
					end
					S_TERM_GO: state_q <= S_TERM_WT;
					S_TERM_WT: begin
						if (div_done) begin
							mc_q <= '0;
							if (k_q == smax_pkg::LAST_TERM) begin
								state_q <= S_FINAL;
							end else begin
								k_q     <= k_q + 5'd1;
								state_q <= S_MUL;
							end
						end
					end
					S_FINAL: state_q <= S_WRITE;
					S_WRITE: begin
						load_pos_q <= load_pos_q + POS_W'(1);
						if (load_end) begin
							axis_pos_q  <= '0;
							inner_pos_q <= '0;
							slot_base_q <= '0;
						end else begin
							axis_pos_q  <= nxt_axis;
							inner_pos_q <= nxt_inner;
							slot_base_q <= nxt_base;
						end
						state_q <= S_OUT;
					end
					S_RD_GO, S_RD_WAIT: begin
						if ((state_q == S_RD_GO && sum_rd == '0) ||
						    (state_q == S_RD_WAIT && div_done)) begin
							if (read_end) begin
								load_pos_q  <= '0;
								read_pos_q  <= '0;
								axis_pos_q  <= '0;
								inner_pos_q <= '0;
								slot_base_q <= '0;
							end else begin
								read_pos_q  <= read_pos_q + POS_W'(1);
								axis_pos_q  <= nxt_axis;
								inner_pos_q <= nxt_inner;
								slot_base_q <= nxt_base;
							end
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD_WAIT;
						end
					end
					S_OUT: begin
						if (!result_valid_q || !result_stall) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == S_OUT && !cfg_hit && (!result_valid_q || !result_stall)) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q   <= item.cmd;
				logit_q <= item.logit;
			end
			S_SHAPE1: slots_q <= 22'(outer_q) * 22'(inner_q);
			S_SHAPE2: total_q <= 31'(slots_q) * 31'(axis_q);
			S_CHECK: begin
				slot_q             <= slot_c;
				pend_q.probability <= '0;
				pend_q.last        <= 1'b0;
				if (bad_shape || (cmd_q == smax_pkg::CMD_LOAD && loaded)) begin
					pend_q.status <= smax_pkg::ST_FULL;
				end else if (cmd_q == smax_pkg::CMD_READ && !loaded) begin
					pend_q.status <= smax_pkg::ST_EARLY;
				end else begin
					pend_q.status <= smax_pkg::ST_OK;
				end
			end
			S_RED_GO: begin
				red_rem_q <= {mag, 47'd0};
				red_quo_q <= '0;
				red_bit_q <= 3'd4;
			end
			S_RED_WAIT: begin
				red_rem_q <= red_rem_nxt;
				red_quo_q <= red_quo_nxt;
				red_bit_q <= red_bit_q - 3'd1;
				if (red_done) begin
					priority if (!logit_q[15]) begin
						sh_q <= 6'd38 - 6'(q0);
						x_q  <= {2'd0, r0, 4'd0};
					end else if (r0 == '0) begin
						sh_q <= 6'd38 + 6'(q0);
						x_q  <= '0;
					end else begin
						sh_q <= 6'd39 + 6'(q0);
						x_q  <= {2'd0, smax_pkg::LN2_Q58 - r0, 4'd0};
					end
					term_q <= smax_pkg::ONE_Q62;
					sum_q  <= smax_pkg::ONE_Q62;
				end
			end
			S_MUL: begin
				pp_s1 <= a_half * b_half;
				sh_s1 <= {1'b0, mc_q[0]} + {1'b0, mc_q[1]};
				if (mc_q == 3'd0) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_q + (128'(pp_s1) << {sh_s1, 5'd0});
				end
			end
			S_TERM_WT: begin
				if (div_done) begin
					term_q <= div_quo;
					sum_q  <= sum_q + div_quo;
				end
			end
			S_FINAL: begin
				sat_q <= e_full > 65'(smax_pkg::EXP_MAX);
				e_q   <= (e_full > 65'(smax_pkg::EXP_MAX)) ? smax_pkg::EXP_MAX : e_full[47:0];
			end
			S_WRITE: pend_q.status <= sat_q ? smax_pkg::ST_SAT : smax_pkg::ST_OK;
			S_RD_GO, S_RD_WAIT: begin
				pend_q.last <= read_end;
				if (state_q == S_RD_GO) begin
					pend_q.probability <= '0;
				end else begin
					pend_q.probability <= div_quo[16:0] + 17'(round_up);
				end
			end
			S_OUT: begin
				if (!result_valid_q || !result_stall) begin
					result_q <= pend_q;
				end
			end
			default: begin
				pend_q <= pend_q;
			end
		endcase
	end

	assign item_stall   = (state_q != S_IDLE) || cfg_hit;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("A new item was taken while the previous one was still in work.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != smax_pkg::ST_OK |-> result.probability == '0)
		else $error("An error or load result carries a nonzero probability.");

	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> result.status == smax_pkg::ST_OK)
		else $error("The final read was flagged with an error status.");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("The shared divider was started while still busy.");

	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.probability <= 17'd65536)
		else $error("A probability above one was produced.");

endmodule

`default_nettype wire

// File: sv/smax_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; holds the stored exponentials and the slot sums of the softmax block.
`default_nettype none

module smax_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: sv/smax_div.sv
// Shared restoring divider, one quotient bit per cycle, for the softmax block.
// Depends on smax_pkg for the operand width.
`default_nettype none

module smax_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [smax_pkg::DIV_W-1:0]  dividend,
	input  wire logic [smax_pkg::DIV_W-1:0]  divisor,
	output logic                             busy,
	output logic                             done,
	output logic      [smax_pkg::DIV_W-1:0]  quotient,
	output logic      [smax_pkg::DIV_W-1:0]  remainder
);

	localparam int W  = smax_pkg::DIV_W;
	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic          fits;

	assign trial = {rem_q[W-1:0], quo_q[W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[W-1:0];

endmodule

`default_nettype wire

// File: sim/softmax_along_axis_tb.sv
// Self-checking testbench for softmax_along_axis: shape phases, loads and reads with random idling.
// A scoreboard class predicts every result in fixed point. Depends on smax_pkg and the block's RTL.
`timescale 1ns / 100ps

module softmax_along_axis_tb;

	localparam int CYCLE_LIMIT = 8000000;
	localparam int ELEMS = 1024;
	localparam int SLOTS = 256;
	localparam int AXIS_MAX = 256;

	class softmax_scoreboard;
		int unsigned outer_n, axis_n, inner_n;
		logic [47:0] exps [ELEMS];
		logic [55:0] sums [SLOTS];
		int unsigned load_pos, read_pos, axis_pos, inner_pos, base;
		smax_pkg::result_t pending_q [$];
		int errors;
		int checked;

		function new();
			outer_n = 1;
			axis_n = 1;
			inner_n = 1;
			errors = 0;
			checked = 0;
			foreach (exps[k]) exps[k] = '0;
			clear();
		endfunction

		function void clear();
			foreach (sums[k]) sums[k] = '0;
			load_pos = 0;
			read_pos = 0;
			axis_pos = 0;
			inner_pos = 0;
			base = 0;
		endfunction

		function void step_counters();
			inner_pos++;
			if (inner_pos >= inner_n) begin
				inner_pos = 0;
				axis_pos++;
				if (axis_pos >= axis_n) begin
					axis_pos = 0;
					base += inner_n;
				end
			end
		endfunction

		function void write_cfg(logic [1:0] idx, logic [10:0] val);
			case (idx)
				smax_pkg::REG_OUTER: outer_n = 32'(val);
				smax_pkg::REG_AXIS: axis_n = 32'(val[8:0]);
				smax_pkg::REG_INNER: inner_n = 32'(val);
				default: return;
			endcase
			clear();
		endfunction

		static function logic [47:0] exp_q24(logic signed [15:0] lg, output logic sat);
			logic [63:0] ln2, mag, y, q0, r0, r, x, term, s, e;
			logic [127:0] prod;
			int n, q, sh;
			ln2 = 64'h02C5C85FDF473DE7;
			n = lg;
			mag = 64'((n < 0) ? -n : n);
			y = mag << 47;
			q0 = y / ln2;
			r0 = y - q0 * ln2;
			if (n >= 0) begin
				q = int'(q0);
				r = r0;
			end else if (r0 == 0) begin
				q = -int'(q0);
				r = 0;
			end else begin
				q = -int'(q0) - 1;
				r = ln2 - r0;
			end
			x = r << 4;
			term = 64'h4000000000000000;
			s = term;
			for (int k = 1; k <= 24; k++) begin
				prod = {64'd0, term} * {64'd0, x};
				term = 64'((prod >> 62) / k);
				s += term;
			end
			sh = 38 - q;
			e = (s + (64'd1 << (sh - 1))) >> sh;
			sat = e > 64'hFFFFFFFFFFFF;
			return sat ? 48'hFFFFFFFFFFFF : e[47:0];
		endfunction

		function void note_item(smax_pkg::item_t it);
			smax_pkg::result_t r;
			longint unsigned total, slot_cnt, d, num, p;
			logic [56:0] acc;
			logic [47:0] e;
			logic sat;
			int unsigned slot;
			r = '0;
			total = longint'(outer_n) * axis_n * inner_n;
			slot_cnt = longint'(outer_n) * inner_n;
			if (total == 0 || axis_n > AXIS_MAX || slot_cnt > SLOTS || total > ELEMS) begin
				r.status = smax_pkg::ST_FULL;
				pending_q.push_back(r);
				return;
			end
			slot = base + inner_pos;
			if (slot >= SLOTS) slot = SLOTS - 1;
			if (it.cmd == smax_pkg::CMD_LOAD) begin
				if (load_pos >= total) begin
					r.status = smax_pkg::ST_FULL;
				end else begin
					e = exp_q24(it.logit, sat);
					exps[load_pos % ELEMS] = e;
					acc = {1'b0, sums[slot]} + 57'(e);
					sums[slot] = acc[56] ? 56'hFFFFFFFFFFFFFF : acc[55:0];
					load_pos++;
					if (load_pos >= total) begin
						axis_pos = 0;
						inner_pos = 0;
						base = 0;
					end else begin
						step_counters();
					end
					r.status = sat ? smax_pkg::ST_SAT : smax_pkg::ST_OK;
				end
			end else if (load_pos < total) begin
				r.status = smax_pkg::ST_EARLY;
			end else begin
				d = 64'(sums[slot]);
				p = 0;
				if (d != 0) begin
					num = longint'(exps[read_pos % ELEMS]) << 16;
					p = num / d;
					if ((num % d) * 2 >= d) p++;
				end
				r.probability = p[16:0];
				read_pos++;
				if (read_pos >= total) begin
					r.last = 1'b1;
					clear();
				end else begin
					step_counters();
				end
			end
			pending_q.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(smax_pkg::result_t got);
			smax_pkg::result_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (got.probability !== want.probability)
				report($sformatf("probability %0d, expected %0d", got.probability,
					want.probability));
			if (got.last !== want.last)
				report($sformatf("last %0b, expected %0b", got.last, want.last));
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [10:0] wr_data;
	logic item_valid;
	logic item_stall;
	smax_pkg::item_t item;
	logic result_valid;
	logic result_stall;
	smax_pkg::result_t result;

	softmax_scoreboard sb;
	bit calm;
	int unsigned cycles;
	int items_sent;
	int tensors_done;

	softmax_along_axis dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[softmax_along_axis] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
	end

	always @(negedge clk) begin
		result_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
	end

	task automatic send(logic cmd, logic signed [15:0] lg);
		smax_pkg::item_t it;
		int gap;
		it.cmd = cmd;
		it.logit = lg;
		gap = (!calm && $urandom_range(99) < 25) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		forever begin
			@(posedge clk);
			if (!item_stall) break;
		end
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		drain();
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.write_cfg(idx, val);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_shape(int o, int a, int i);
		write_reg(smax_pkg::REG_OUTER, 11'(o));
		write_reg(smax_pkg::REG_AXIS, 11'(a));
		write_reg(smax_pkg::REG_INNER, 11'(i));
	endtask

	function automatic logic signed [15:0] rand_logit();
		if ($urandom_range(3) == 0) return 16'($urandom_range(65535));
		return 16'($signed($urandom_range(24575)) - 12288);
	endfunction

	task automatic run_tensor(int o, int a, int i, bit noisy, bit hold);
		int total;
		total = o * a * i;
		set_shape(o, a, i);
		for (int n = 0; n < total; n++) begin
			if (noisy && $urandom_range(9) == 0) send(smax_pkg::CMD_READ, rand_logit());
			if (hold && n == total / 2) drain();
			send(smax_pkg::CMD_LOAD, rand_logit());
		end
		if (noisy && $urandom_range(3) == 0) send(smax_pkg::CMD_LOAD, rand_logit());
		for (int n = 0; n < total; n++)
			send(smax_pkg::CMD_READ, 16'($urandom_range(65535)));
		tensors_done++;
	endtask

	task automatic abort_after_loads(int o, int a, int i, int n);
		set_shape(o, a, i);
		repeat (n) send(smax_pkg::CMD_LOAD, rand_logit());
	endtask

	initial begin
		int o, a, i;
		sb = new();
		cycles = 0;
		items_sent = 0;
		tensors_done = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(smax_pkg::CMD_READ, 16'sd0);
		send(smax_pkg::CMD_LOAD, -16'sd32768);
		send(smax_pkg::CMD_LOAD, 16'sd5);
		send(smax_pkg::CMD_READ, 16'sd0);
		set_shape(2, 3, 2);
		send(smax_pkg::CMD_LOAD, 16'sd32767);
		send(smax_pkg::CMD_LOAD, -16'sd32768);
		send(smax_pkg::CMD_READ, 16'sd0);
		send(smax_pkg::CMD_LOAD, 16'sd0);
		send(smax_pkg::CMD_LOAD, 16'sd1);
		send(smax_pkg::CMD_LOAD, -16'sd1);
		send(smax_pkg::CMD_LOAD, 16'sd2048);
		send(smax_pkg::CMD_LOAD, -16'sd2048);
		send(smax_pkg::CMD_LOAD, 16'sd1420);
		send(smax_pkg::CMD_LOAD, -16'sd1420);
		send(smax_pkg::CMD_LOAD, 16'sd30000);
		send(smax_pkg::CMD_LOAD, -16'sd30000);
		send(smax_pkg::CMD_LOAD, 16'sd1);
		for (int n = 0; n < 12; n++) send(smax_pkg::CMD_READ, 16'sd0);
		set_shape(0, 1, 1);
		send(smax_pkg::CMD_LOAD, 16'sd0);
		send(smax_pkg::CMD_READ, 16'sd0);
		set_shape(1, 257, 1);
		send(smax_pkg::CMD_LOAD, 16'sd0);
		set_shape(2047, 511, 2047);
		send(smax_pkg::CMD_READ, 16'sd0);
		set_shape(1, 1, 1024);
		send(smax_pkg::CMD_LOAD, 16'sd0);
		set_shape(17, 1, 16);
		send(smax_pkg::CMD_LOAD, 16'sd0);
		abort_after_loads(1024, 1, 1, 3);
		abort_after_loads(1, 256, 1, 3);
		abort_after_loads(1, 1, 256, 3);
		abort_after_loads(2, 2, 2, 3);
		send(smax_pkg::CMD_READ, 16'sd0);

		while (items_sent < 1150) begin
			calm = (tensors_done % 12) >= 9;
			do begin
				o = $urandom_range(1, 4);
				a = $urandom_range(1, 8);
				i = $urandom_range(1, 4);
			end while (o * a * i > 24);
			if ($urandom_range(15) == 0) begin
				abort_after_loads(o, a, i, $urandom_range(1, 3));
			end else begin
				run_tensor(o, a, i, $urandom_range(3) != 0, tensors_done == 5);
			end
		end

		drain();
		repeat (2000) @(posedge clk);
		if (sb.pending_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
		$display("Sent %0d items over %0d full tensors, checked %0d results,",
			items_sent, tensors_done, sb.checked);
		$display("including bad shapes, early reads, aborted tensors and extreme logits.");
		if (sb.errors == 0) begin
			$display("[softmax_along_axis] OK");
		end else begin
			$display("[softmax_along_axis] ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
sv/smax_pkg.sv
sv/smax_ram.sv
sv/smax_div.sv
sv/softmax_along_axis.sv
sim/softmax_along_axis_tb.sv
